// ----- src/btos_pkg.sv -----
// Shared types, codes and constants of the binary trie order-statistic multiset.
package btos_pkg;

    localparam int KEY_BITS_DEF  = 20;
    localparam int NODE_POOL_DEF = 2048;

    localparam int OP_W  = 2;
    localparam int KEY_W = 20;
    localparam int K_W   = 16;
    localparam int ANS_W = 20;
    localparam int ST_W  = 2;
    localparam int CNT_W = 16;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_RANK   = 2'd2,
        OP_SELECT = 2'd3
    } op_t;

    typedef enum logic [ST_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_POOL_FULL = 2'd1,
        STAT_ABSENT    = 2'd2,
        STAT_OVERFLOW  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        SEQ_CLEAR,
        SEQ_IDLE,
        SEQ_WALK,
        SEQ_DECIDE,
        SEQ_COMMIT
    } seq_state_t;

    typedef struct packed {
        op_t  op;
        logic commit;
        logic key_bit;
    } step_ctl_t;

    typedef struct packed {
        logic link_zero;
        logic cnt_full;
        logic cnt_zero;
        logic cnt_lt_k;
        logic take_right;
    } step_flags_t;

endpackage

// ----- src/btos_step.sv -----
// One trie level: child choice, count update and the shared adder.
module btos_step #(
    parameter int KEY_BITS  = btos_pkg::KEY_BITS_DEF,
    parameter int NODE_POOL = btos_pkg::NODE_POOL_DEF,
    localparam int LINK_W   = $clog2(NODE_POOL),
    localparam int ROW_W    = 2 * LINK_W + 2 * btos_pkg::CNT_W,
    localparam int ACC_W    = btos_pkg::CNT_W + $clog2(KEY_BITS + 1)
) (
    input  logic [ROW_W-1:0]          row,
    input  btos_pkg::step_ctl_t       ctl,
    input  logic [ACC_W-1:0]          acc,
    input  logic [btos_pkg::K_W-1:0]  k,
    input  logic [LINK_W-1:0]         free_node,
    output logic [ROW_W-1:0]          row_new,
    output logic [LINK_W-1:0]         child,
    output logic [ACC_W-1:0]          acc_new,
    output logic [btos_pkg::K_W-1:0]  k_new,
    output btos_pkg::step_flags_t     flags
);

    localparam int CNT_W = btos_pkg::CNT_W;

    logic [LINK_W-1:0] link0;
    logic [LINK_W-1:0] link1;
    logic [LINK_W-1:0] link_sel;
    logic [CNT_W-1:0]  cnt0;
    logic [CNT_W-1:0]  cnt1;
    logic [CNT_W-1:0]  cnt_sel;
    logic [ACC_W-1:0]  opa;
    logic [ACC_W-1:0]  opb;
    logic [ACC_W-1:0]  sum;
    logic              cin;
    logic              dir;

    assign link0 = row[LINK_W-1:0];
    assign link1 = row[2*LINK_W-1:LINK_W];
    assign cnt0  = row[2*LINK_W+CNT_W-1:2*LINK_W];
    assign cnt1  = row[ROW_W-1:2*LINK_W+CNT_W];

    // The one adder serves every operation: rank sum, select subtract,
    // count increment and count decrement.
    always_comb
    begin
        opa = '0;
        opb = '0;
        cin = 1'b0;
        case (ctl.op)
            btos_pkg::OP_INSERT:
            begin
                opa = ACC_W'(ctl.key_bit ? cnt1 : cnt0);
                cin = 1'b1;
            end
            btos_pkg::OP_REMOVE:
            begin
                opa = ACC_W'(ctl.key_bit ? cnt1 : cnt0);
                opb = '1;
            end
            btos_pkg::OP_RANK:
            begin
                opa = acc;
                opb = ctl.key_bit ? ACC_W'(cnt0) : '0;
            end
            btos_pkg::OP_SELECT:
            begin
                opa = ACC_W'(k);
                opb = ~ACC_W'(cnt0);
                cin = 1'b1;
            end
            default:
            begin
                opa = '0;
            end
        endcase
        sum = opa + opb + ACC_W'(cin);
    end

    // Select goes right when the left subtree holds fewer than k values.
    assign dir = (ctl.op == btos_pkg::OP_SELECT) ? (!sum[ACC_W-1] && (sum != '0))
                                                 : ctl.key_bit;

    assign link_sel = dir ? link1 : link0;
    assign cnt_sel  = dir ? cnt1 : cnt0;
    assign child    = (ctl.commit && (ctl.op == btos_pkg::OP_INSERT) && (link_sel == '0))
                      ? free_node : link_sel;
    assign acc_new  = sum;
    assign k_new    = ((ctl.op == btos_pkg::OP_SELECT) && dir) ? sum[btos_pkg::K_W-1:0] : k;

    always_comb
    begin
        row_new = row;
        if (dir)
        begin
            row_new[2*LINK_W-1:LINK_W]          = child;
            row_new[ROW_W-1:2*LINK_W+CNT_W]     = sum[CNT_W-1:0];
        end
        else
        begin
            row_new[LINK_W-1:0]                 = child;
            row_new[2*LINK_W+CNT_W-1:2*LINK_W]  = sum[CNT_W-1:0];
        end
    end

    assign flags.link_zero  = (link_sel == '0);
    assign flags.cnt_full   = (cnt_sel == '1);
    assign flags.cnt_zero   = (cnt_sel == '0);
    assign flags.cnt_lt_k   = (cnt_sel < k_new);
    assign flags.take_right = dir;

endmodule

// ----- src/binary_trie_order_statistics.sv -----
// Top level of the binary trie order-statistic multiset with its node memory.
//
//   word        handshake                    fields
//   ----------  ---------------------------  ---------------------------------
//   command     start high while busy low    opcode, key_value, order_k
//   result      done high for one cycle      answer, found, status
//
// Rank and select walk the trie path once; insert and remove walk it once to
// check it and once more to commit it, and a refused insert or remove ends
// right after the check. Each walk step is one read of the node memory,
// whose single read port and the shared adder in the level unit set the pace
// of one trie level a cycle. After reset the block clears the node memory
// one row a cycle and holds busy high meanwhile. The result word is shown
// for one cycle on done and cannot be stalled; a new command may be taken in
// that same cycle.
//
// Each memory row belongs to one node and holds both child links and the
// counts of both children, so one read per level gives everything a step
// needs. Node 0 means no node; its row stays zero, so a walk that has left
// the trie keeps reading zero links and zero counts.
module binary_trie_order_statistics #(
    parameter int KEY_BITS  = btos_pkg::KEY_BITS_DEF,
    parameter int NODE_POOL = btos_pkg::NODE_POOL_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [btos_pkg::OP_W-1:0]  opcode,
    input  logic [btos_pkg::KEY_W-1:0] key_value,
    input  logic [btos_pkg::K_W-1:0]   order_k,
    output logic                       done,
    output logic [btos_pkg::ANS_W-1:0] answer,
    output logic                       found,
    output logic [btos_pkg::ST_W-1:0]  status
);

    localparam int CNT_W  = btos_pkg::CNT_W;
    localparam int K_W    = btos_pkg::K_W;
    localparam int ANS_W  = btos_pkg::ANS_W;
    localparam int KEY_W  = btos_pkg::KEY_W;
    localparam int LINK_W = $clog2(NODE_POOL);
    localparam int ROW_W  = 2 * LINK_W + 2 * CNT_W;
    localparam int ACC_W  = CNT_W + $clog2(KEY_BITS + 1);
    localparam int IDX_W  = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
    localparam int MISS_W = $clog2(KEY_BITS + 1);
    localparam int FREE_W = $clog2(NODE_POOL + 1);

    // Node memory: one row per node.
    logic [ROW_W-1:0] mem [NODE_POOL];
    logic [ROW_W-1:0] rd_reg;
    logic [LINK_W-1:0] raddr;
    logic [LINK_W-1:0] waddr;
    logic [ROW_W-1:0]  wdata;
    logic              we;

    btos_pkg::seq_state_t state_reg, state_next;
    btos_pkg::op_t        op_reg, op_next;
    logic [KEY_BITS-1:0]  key_reg, key_next;
    logic [K_W-1:0]       k_reg, k_next;
    logic [IDX_W-1:0]     bit_reg, bit_next;
    logic [LINK_W-1:0]    node_reg, node_next;
    logic [ACC_W-1:0]     acc_reg, acc_next;
    logic [KEY_BITS-1:0]  val_reg, val_next;
    logic [MISS_W-1:0]    miss_reg, miss_next;
    logic                 bad_reg, bad_next;
    logic [FREE_W-1:0]    free_reg, free_next;
    logic [LINK_W-1:0]    clr_reg, clr_next;

    logic                 done_reg, done_next;
    logic [ANS_W-1:0]     answer_reg, answer_next;
    logic                 found_reg, found_next;
    btos_pkg::status_t    status_reg, status_next;

    btos_pkg::step_ctl_t   ctl;
    btos_pkg::step_flags_t flags;
    logic [ROW_W-1:0]      row_new;
    logic [LINK_W-1:0]     child;
    logic [ACC_W-1:0]      acc_new;
    logic [K_W-1:0]        k_new;

    logic                      accept;
    logic                      last_level;
    logic                      pool_full;
    logic [KEY_BITS-1:0]       bit_mask;
    logic [KEY_BITS-1:0]       sel_val;
    logic                      sel_fail;
    logic [KEY_BITS+KEY_W-1:0] key_wide;
    logic [KEY_BITS+ANS_W-1:0] val_wide;

    assign accept     = start && (state_reg == btos_pkg::SEQ_IDLE);
    assign busy       = (state_reg != btos_pkg::SEQ_IDLE);
    assign last_level = (bit_reg == '0);

    // Only the low KEY_BITS bits of the key take part; wider keys are zero
    // above the port width.
    assign key_wide = {{KEY_BITS{1'b0}}, key_value};
    assign bit_mask = KEY_BITS'(1) << bit_reg;
    assign sel_val  = flags.take_right ? (val_reg | bit_mask) : val_reg;
    assign val_wide = {{ANS_W{1'b0}}, sel_val};
    assign sel_fail = bad_reg || flags.link_zero || (last_level && flags.cnt_lt_k);

    assign pool_full = ((FREE_W + 1)'(free_reg) + (FREE_W + 1)'(miss_reg))
                       > (FREE_W + 1)'(NODE_POOL);

    assign ctl.op      = op_reg;
    assign ctl.commit  = (state_reg == btos_pkg::SEQ_COMMIT);
    assign ctl.key_bit = key_reg[bit_reg];

    btos_step #(
        .KEY_BITS  (KEY_BITS),
        .NODE_POOL (NODE_POOL)
    ) u_step (
        .row       (rd_reg),
        .ctl       (ctl),
        .acc       (acc_reg),
        .k         (k_reg),
        .free_node (free_reg[LINK_W-1:0]),
        .row_new   (row_new),
        .child     (child),
        .acc_new   (acc_new),
        .k_new     (k_new),
        .flags     (flags)
    );

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            btos_pkg::SEQ_CLEAR:
            begin
                if (clr_reg == LINK_W'(NODE_POOL - 1))
                    state_next = btos_pkg::SEQ_IDLE;
            end
            btos_pkg::SEQ_IDLE:
            begin
                if (start)
                    state_next = btos_pkg::SEQ_WALK;
            end
            btos_pkg::SEQ_WALK:
            begin
                if (last_level)
                begin
                    if ((op_reg == btos_pkg::OP_INSERT) || (op_reg == btos_pkg::OP_REMOVE))
                        state_next = btos_pkg::SEQ_DECIDE;
                    else
                        state_next = btos_pkg::SEQ_IDLE;
                end
            end
            btos_pkg::SEQ_DECIDE:
            begin
                if (((op_reg == btos_pkg::OP_INSERT) && (pool_full || bad_reg)) ||
                    ((op_reg == btos_pkg::OP_REMOVE) && bad_reg))
                    state_next = btos_pkg::SEQ_IDLE;
                else
                    state_next = btos_pkg::SEQ_COMMIT;
            end
            btos_pkg::SEQ_COMMIT:
            begin
                if (last_level)
                    state_next = btos_pkg::SEQ_IDLE;
            end
            default:
            begin
                state_next = btos_pkg::SEQ_IDLE;
            end
        endcase
    end

    // Datapath, memory control and result word.
    always_comb
    begin
        op_next     = op_reg;
        key_next    = key_reg;
        k_next      = k_reg;
        bit_next    = bit_reg;
        node_next   = node_reg;
        acc_next    = acc_reg;
        val_next    = val_reg;
        miss_next   = miss_reg;
        bad_next    = bad_reg;
        free_next   = free_reg;
        clr_next    = clr_reg;
        done_next   = 1'b0;
        answer_next = answer_reg;
        found_next  = found_reg;
        status_next = status_reg;
        raddr       = node_reg;
        waddr       = clr_reg;
        wdata       = '0;
        we          = 1'b0;

        case (state_reg)
            btos_pkg::SEQ_CLEAR:
            begin
                we       = 1'b1;
                waddr    = clr_reg;
                clr_next = clr_reg + 1'b1;
            end
            btos_pkg::SEQ_IDLE:
            begin
                if (accept)
                begin
                    op_next   = btos_pkg::op_t'(opcode);
                    key_next  = key_wide[KEY_BITS-1:0];
                    k_next    = order_k;
                    bit_next  = IDX_W'(KEY_BITS - 1);
                    node_next = LINK_W'(1);
                    acc_next  = '0;
                    val_next  = '0;
                    miss_next = '0;
                    bad_next  = (btos_pkg::op_t'(opcode) == btos_pkg::OP_SELECT) &&
                                (order_k == '0);
                    raddr     = LINK_W'(1);
                end
            end
            btos_pkg::SEQ_WALK:
            begin
                raddr     = child;
                node_next = child;
                if (!last_level)
                    bit_next = bit_reg - 1'b1;
                case (op_reg)
                    btos_pkg::OP_INSERT:
                    begin
                        miss_next = miss_reg + MISS_W'(flags.link_zero);
                        if (flags.cnt_full)
                            bad_next = 1'b1;
                    end
                    btos_pkg::OP_REMOVE:
                    begin
                        if (last_level && flags.cnt_zero)
                            bad_next = 1'b1;
                    end
                    btos_pkg::OP_RANK:
                    begin
                        acc_next = acc_new;
                        if (last_level)
                        begin
                            done_next   = 1'b1;
                            answer_next = acc_new[ANS_W-1:0];
                            found_next  = 1'b1;
                            status_next = btos_pkg::STAT_OK;
                        end
                    end
                    btos_pkg::OP_SELECT:
                    begin
                        k_next   = k_new;
                        val_next = sel_val;
                        if (sel_fail)
                            bad_next = 1'b1;
                        if (last_level)
                        begin
                            done_next   = 1'b1;
                            answer_next = sel_fail ? '0 : val_wide[ANS_W-1:0];
                            found_next  = !sel_fail;
                            status_next = btos_pkg::STAT_OK;
                        end
                    end
                    default:
                    begin
                        bad_next = bad_reg;
                    end
                endcase
            end
            btos_pkg::SEQ_DECIDE:
            begin
                // Pool exhaustion is checked before a saturated count.
                raddr     = LINK_W'(1);
                node_next = LINK_W'(1);
                bit_next  = IDX_W'(KEY_BITS - 1);
                if ((op_reg == btos_pkg::OP_INSERT) && pool_full)
                begin
                    done_next   = 1'b1;
                    answer_next = '0;
                    found_next  = 1'b0;
                    status_next = btos_pkg::STAT_POOL_FULL;
                end
                else if ((op_reg == btos_pkg::OP_INSERT) && bad_reg)
                begin
                    done_next   = 1'b1;
                    answer_next = '0;
                    found_next  = 1'b0;
                    status_next = btos_pkg::STAT_OVERFLOW;
                end
                else if ((op_reg == btos_pkg::OP_REMOVE) && bad_reg)
                begin
                    done_next   = 1'b1;
                    answer_next = '0;
                    found_next  = 1'b0;
                    status_next = btos_pkg::STAT_ABSENT;
                end
            end
            btos_pkg::SEQ_COMMIT:
            begin
                // Write back the updated row of this node while fetching the next.
                we        = 1'b1;
                waddr     = node_reg;
                wdata     = row_new;
                raddr     = child;
                node_next = child;
                if ((op_reg == btos_pkg::OP_INSERT) && flags.link_zero)
                    free_next = free_reg + 1'b1;
                if (!last_level)
                    bit_next = bit_reg - 1'b1;
                else
                begin
                    done_next   = 1'b1;
                    answer_next = '0;
                    found_next  = 1'b1;
                    status_next = btos_pkg::STAT_OK;
                end
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rd_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= btos_pkg::SEQ_CLEAR;
            clr_reg   <= '0;
            free_reg  <= FREE_W'(2);
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            free_reg  <= free_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        k_reg      <= k_next;
        bit_reg    <= bit_next;
        node_reg   <= node_next;
        acc_reg    <= acc_next;
        val_reg    <= val_next;
        miss_reg   <= miss_next;
        bad_reg    <= bad_next;
        answer_reg <= answer_next;
        found_reg  <= found_next;
        status_reg <= status_next;
    end

    assign done   = done_reg;
    assign answer = answer_reg;
    assign found  = found_reg;
    assign status = status_reg;

endmodule

// ----- src/btos_checker.sv -----
// Port-level checks of the trie multiset and their attachment to the top level.
module btos_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       done,
    input logic [btos_pkg::ANS_W-1:0] answer,
    input logic                       found,
    input logic [btos_pkg::ST_W-1:0]  status
);

    // A result word only appears once the block is free again.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result word shown while busy");

    // An accepted command occupies the block and never answers at once.
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> (busy && !done))
        else $error("accepted command did not make the block busy");

    // Every command keeps the block busy before it answers, so result words never touch.
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("two result words in a row");

    // A refused operation carries no answer and is not marked found.
    assert property (@(posedge clk) disable iff (!rst_n)
                     (done && (status != btos_pkg::STAT_OK)) |-> (!found && (answer == '0)))
        else $error("refused operation with answer or found set");

    // A not-found result always carries a zero answer.
    assert property (@(posedge clk) disable iff (!rst_n) (done && !found) |-> (answer == '0))
        else $error("not-found result with nonzero answer");

endmodule

bind binary_trie_order_statistics btos_checker u_btos_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .answer (answer),
    .found  (found),
    .status (status)
);

// ----- verif/binary_trie_order_statistics_tb.sv -----
// Self-checking testbench for the binary trie order-statistic multiset.
`timescale 1ns / 100ps

module binary_trie_order_statistics_tb;

    localparam int KEY_BITS     = btos_pkg::KEY_BITS_DEF;
    localparam int NODE_POOL    = btos_pkg::NODE_POOL_DEF;
    localparam int OP_W         = btos_pkg::OP_W;
    localparam int KEY_W        = btos_pkg::KEY_W;
    localparam int K_W          = btos_pkg::K_W;
    localparam int ANS_W        = btos_pkg::ANS_W;
    localparam int ST_W         = btos_pkg::ST_W;
    localparam int CNT_W        = btos_pkg::CNT_W;
    localparam int LINK_W       = $clog2(NODE_POOL);
    localparam int RANDOM_WORDS = 1750;
    localparam int FILL_TRIES   = 400;
    localparam int MAX_REPORTS  = 40;
    // Insert and remove walk the path twice; leave some slack after the last result.
    localparam int DRAIN_CYCLES = 2 * KEY_BITS + 12;
    // The slowest correct run is about 2200 words, each a full insert or remove
    // with the longest gap after it, plus the clear pass after reset. The limit
    // is well above that.
    localparam longint TIMEOUT_CYCLES = 1_000_000;

    localparam logic [LINK_W-1:0] ROOT      = LINK_W'(1);
    localparam logic [CNT_W-1:0]  COUNT_SAT = '1;

    // One expected result word.
    typedef struct packed {
        logic [ANS_W-1:0]  answer;
        logic              found;
        btos_pkg::status_t status;
    } outcome_t;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             start     = 1'b0;
    logic [OP_W-1:0]  opcode    = '0;
    logic [KEY_W-1:0] key_value = '0;
    logic [K_W-1:0]   order_k   = '0;
    logic             busy;
    logic             done;
    logic [ANS_W-1:0] answer;
    logic             found;
    logic [ST_W-1:0]  status;

    // Shadow copy of the trie: child links, node counts and the allocation pointer.
    logic [LINK_W-1:0] trie_link [0:2*NODE_POOL-1];
    logic [CNT_W-1:0]  trie_count [0:NODE_POOL-1];
    int unsigned       alloc_next;

    outcome_t         pending_outcomes [$];
    logic [KEY_W-1:0] stored_keys [$];
    int unsigned      mismatch_count = 0;
    int unsigned      result_index   = 0;
    longint           cycle_count    = 0;

    binary_trie_order_statistics dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .opcode    (opcode),
        .key_value (key_value),
        .order_k   (order_k),
        .done      (done),
        .answer    (answer),
        .found     (found),
        .status    (status)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Trie predictor
    // ------------------------------------------------------------------

    // Child of a node for one key bit; node 0 has no children.
    function automatic logic [LINK_W-1:0] link_of(logic [LINK_W-1:0] node, logic b);
        return trie_link[{node, b}];
    endfunction

    function automatic logic [CNT_W-1:0] count_of(logic [LINK_W-1:0] node);
        return trie_count[node];
    endfunction

    // Insert checks the whole path first (nodes missing, saturated counts) and only
    // then commits, so a refused insert leaves the trie untouched.
    function automatic btos_pkg::status_t trie_insert(logic [KEY_W-1:0] key);
        logic [LINK_W-1:0] node;
        logic [LINK_W-1:0] nxt;
        int unsigned       missing;
        logic              saturated;
        node      = ROOT;
        missing   = 0;
        saturated = 1'b0;
        for (int i = KEY_BITS - 1; i >= 0; i--)
        begin
            nxt = (node != 0) ? link_of(node, key[i]) : '0;
            if (nxt == 0)
            begin
                missing++;
                node = '0;
            end
            else
            begin
                if (count_of(nxt) == COUNT_SAT)
                    saturated = 1'b1;
                node = nxt;
            end
        end
        // Running out of nodes takes priority over a saturated count.
        if (alloc_next + missing > NODE_POOL)
            return btos_pkg::STAT_POOL_FULL;
        if (saturated)
            return btos_pkg::STAT_OVERFLOW;
        node = ROOT;
        for (int i = KEY_BITS - 1; i >= 0; i--)
        begin
            if (link_of(node, key[i]) == 0)
            begin
                trie_link[{node, key[i]}] = LINK_W'(alloc_next);
                alloc_next++;
            end
            node = link_of(node, key[i]);
            trie_count[node] = trie_count[node] + 1'b1;
        end
        return btos_pkg::STAT_OK;
    endfunction

    // A remove is refused when the path is incomplete or the leaf holds no copy.
    // Emptied nodes stay allocated.
    function automatic btos_pkg::status_t trie_remove(logic [KEY_W-1:0] key);
        logic [LINK_W-1:0] node;
        node = ROOT;
        for (int i = KEY_BITS - 1; i >= 0; i--)
        begin
            node = link_of(node, key[i]);
            if (node == 0)
                return btos_pkg::STAT_ABSENT;
        end
        if (count_of(node) == 0)
            return btos_pkg::STAT_ABSENT;
        node = ROOT;
        for (int i = KEY_BITS - 1; i >= 0; i--)
        begin
            node = link_of(node, key[i]);
            trie_count[node] = trie_count[node] - 1'b1;
        end
        return btos_pkg::STAT_OK;
    endfunction

    // Number of stored values strictly below the key: every time the key goes
    // right, the whole left subtree is smaller.
    function automatic logic [ANS_W-1:0] trie_rank(logic [KEY_W-1:0] key);
        logic [LINK_W-1:0] node;
        int unsigned       below;
        node  = ROOT;
        below = 0;
        for (int i = KEY_BITS - 1; i >= 0; i--)
        begin
            if (key[i])
                below += count_of(link_of(node, 1'b0));
            node = link_of(node, key[i]);
            if (node == 0)
                break;
        end
        return ANS_W'(below);
    endfunction

    // k-th smallest value, one-based. Zero k, or k above the number stored, is
    // not found.
    function automatic logic trie_select(logic [K_W-1:0] k_in, output logic [ANS_W-1:0] value);
        int unsigned       k;
        int unsigned       left_count;
        logic [LINK_W-1:0] node;
        logic [LINK_W-1:0] left;
        logic [KEY_W-1:0]  acc;
        logic              ok;
        value = '0;
        k     = k_in;
        node  = ROOT;
        acc   = '0;
        ok    = (k != 0);
        for (int i = KEY_BITS - 1; i >= 0 && ok; i--)
        begin
            left       = link_of(node, 1'b0);
            left_count = count_of(left);
            if (left_count >= k)
                node = left;
            else
            begin
                k      -= left_count;
                node    = link_of(node, 1'b1);
                acc[i]  = 1'b1;
            end
            if (node == 0)
                ok = 1'b0;
        end
        if (ok && count_of(node) < k)
            ok = 1'b0;
        if (ok)
            value = ANS_W'(acc);
        return ok;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Idle gap between command words: mostly none or short, now and then long.
    function automatic int unsigned rand_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    // Offers one command word, waits until the block takes it, predicts its result
    // word and then idles for the given gap. With no gap, start stays high so the
    // next word follows at once.
    task automatic send_word(btos_pkg::op_t op, logic [KEY_W-1:0] key, logic [K_W-1:0] k,
                             int unsigned gap);
        outcome_t         want;
        logic [ANS_W-1:0] sel_value;
        start     <= 1'b1;
        opcode    <= op;
        key_value <= key;
        order_k   <= k;
        // Signals read right after the edge still hold their pre-edge values.
        do
            @(posedge clk);
        while (busy);
        want = '0;
        case (op)
            btos_pkg::OP_INSERT:
            begin
                want.status = trie_insert(key);
                want.found  = (want.status == btos_pkg::STAT_OK);
                if (want.status == btos_pkg::STAT_OK && stored_keys.size() < 512)
                    stored_keys.push_back(key);
            end
            btos_pkg::OP_REMOVE:
            begin
                want.status = trie_remove(key);
                want.found  = (want.status == btos_pkg::STAT_OK);
            end
            btos_pkg::OP_RANK:
            begin
                want.answer = trie_rank(key);
                want.found  = 1'b1;
            end
            default:
            begin
                want.found  = trie_select(k, sel_value);
                want.answer = sel_value;
            end
        endcase
        pending_outcomes.push_back(want);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic flag_mismatch(string msg);
        if (mismatch_count < MAX_REPORTS)
            $display("[%0t] MISMATCH %s", $time, msg);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Result checker: each result word is compared with the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && done)
        begin
            if (pending_outcomes.size() == 0)
                flag_mismatch($sformatf("result word %0d with nothing expected: answer %0h",
                                        result_index, answer));
            else
            begin
                want = pending_outcomes.pop_front();
                if (answer !== want.answer)
                    flag_mismatch($sformatf("result word %0d answer %0h, expected %0h",
                                            result_index, answer, want.answer));
                if (found !== want.found)
                    flag_mismatch($sformatf("result word %0d found %0b, expected %0b",
                                            result_index, found, want.found));
                if (status !== want.status)
                    flag_mismatch($sformatf("result word %0d status %0d, expected %0d",
                                            result_index, status, want.status));
            end
            result_index++;
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > TIMEOUT_CYCLES)
        begin
            $display("binary_trie_order_statistics verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Queries and removes on an empty trie: rank is zero, select finds nothing,
    // removes are refused as absent.
    task automatic test_empty_trie();
        send_word(btos_pkg::OP_RANK,   '0,                 K_W'($urandom()), rand_gap());
        send_word(btos_pkg::OP_RANK,   '1,                 K_W'($urandom()), rand_gap());
        send_word(btos_pkg::OP_SELECT, KEY_W'($urandom()), 16'd1,            rand_gap());
        send_word(btos_pkg::OP_SELECT, KEY_W'($urandom()), 16'd0,            rand_gap());
        send_word(btos_pkg::OP_SELECT, KEY_W'($urandom()), '1,               rand_gap());
        send_word(btos_pkg::OP_REMOVE, '0,                 K_W'($urandom()), rand_gap());
        send_word(btos_pkg::OP_REMOVE, '1,                 K_W'($urandom()), rand_gap());
    endtask

    // Every operation on a few extreme and patterned keys, with a duplicate,
    // select past the end, a remove that empties nodes, and removes of values
    // that are absent with and without a stored path.
    task automatic test_directed_ops();
        send_word(btos_pkg::OP_INSERT, '0,        K_W'($urandom()), rand_gap());
        send_word(btos_pkg::OP_INSERT, '1,        K_W'($urandom()), rand_gap());
        send_word(btos_pkg::OP_INSERT, '0,        K_W'($urandom()), rand_gap());
        send_word(btos_pkg::OP_INSERT, 20'h55555, K_W'($urandom()), rand_gap());
        send_word(btos_pkg::OP_INSERT, 20'hAAAAA, K_W'($urandom()), rand_gap());
        send_word(btos_pkg::OP_RANK,   '0,        K_W'($urandom()), rand_gap());
        send_word(btos_pkg::OP_RANK,   '1,        K_W'($urandom()), rand_gap());
        send_word(btos_pkg::OP_RANK,   20'hAAAAA, K_W'($urandom()), rand_gap());
        send_word(btos_pkg::OP_RANK,   20'h55556, K_W'($urandom()), rand_gap());
        send_word(btos_pkg::OP_SELECT, KEY_W'($urandom()), 16'd1, rand_gap());
        send_word(btos_pkg::OP_SELECT, KEY_W'($urandom()), 16'd2, rand_gap());
        send_word(btos_pkg::OP_SELECT, KEY_W'($urandom()), 16'd5, rand_gap());
        send_word(btos_pkg::OP_SELECT, KEY_W'($urandom()), 16'd6, rand_gap());
        send_word(btos_pkg::OP_SELECT, KEY_W'($urandom()), 16'd0, rand_gap());
        send_word(btos_pkg::OP_REMOVE, '0,        K_W'($urandom()), rand_gap());
        send_word(btos_pkg::OP_REMOVE, '0,        K_W'($urandom()), rand_gap());
        send_word(btos_pkg::OP_REMOVE, '0,        K_W'($urandom()), rand_gap());
        send_word(btos_pkg::OP_REMOVE, 20'h12345, K_W'($urandom()), rand_gap());
        // Key zero's path is emptied below its first node; select must step over it.
        send_word(btos_pkg::OP_SELECT, KEY_W'($urandom()), 16'd1, rand_gap());
        send_word(btos_pkg::OP_RANK,   20'h00001, K_W'($urandom()), rand_gap());
    endtask

    // Random mix. Most keys are stored keys, their neighbors or members of a few
    // clusters sharing their upper bits, so inserts, removes and queries meet real
    // paths; fully random keys use up the pool over the run and bring on refusals.
    task automatic test_random_mix();
        logic [KEY_W-1:0] bases [4];
        logic [KEY_W-1:0] key;
        logic [K_W-1:0]   k;
        btos_pkg::op_t    op;
        int unsigned      r;
        int unsigned      total;
        logic             burst;
        for (int b = 0; b < 4; b++)
            bases[b] = KEY_W'($urandom());
        burst = 1'b0;
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            // Some stretches run back to back with no idling at all.
            if (n % 100 == 0)
                burst = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 40 && stored_keys.size() != 0)
                key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
            else if (r < 55 && stored_keys.size() != 0)
                key = stored_keys[$urandom_range(0, stored_keys.size() - 1)]
                      + ($urandom_range(0, 1) ? KEY_W'(1) : '1);
            else if (r < 85)
                key = bases[$urandom_range(0, 3)] ^ KEY_W'($urandom_range(0, 63));
            else if (r < 90)
                key = $urandom_range(0, 1) ? '1 : '0;
            else
                key = KEY_W'($urandom());
            r = $urandom_range(0, 99);
            if (r < 35)
                op = btos_pkg::OP_INSERT;
            else if (r < 55)
                op = btos_pkg::OP_REMOVE;
            else if (r < 75)
                op = btos_pkg::OP_RANK;
            else
                op = btos_pkg::OP_SELECT;
            total = count_of(link_of(ROOT, 1'b0)) + count_of(link_of(ROOT, 1'b1));
            r = $urandom_range(0, 9);
            if (r == 0)
                k = '0;
            else if (r == 1)
                k = K_W'($urandom());
            else
                k = K_W'($urandom_range(1, total + 2));
            send_word(op, key, k, burst ? 0 : rand_gap());
        end
    endtask

    // Stores scattered keys until fewer nodes remain than one new path may need
    // or FILL_TRIES inserts have been sent, then checks that new paths are refused
    // as pool full while inserts, removes and queries on stored paths keep working.
    task automatic test_pool_exhaustion();
        int unsigned tries;
        tries = 0;
        while ((alloc_next + KEY_BITS <= NODE_POOL) && (tries < FILL_TRIES))
        begin
            send_word(btos_pkg::OP_INSERT, KEY_W'($urandom()), K_W'($urandom()), 0);
            tries++;
        end
        for (int n = 0; n < 12; n++)
            send_word(btos_pkg::OP_INSERT, KEY_W'($urandom()), K_W'($urandom()), rand_gap());
        send_word(btos_pkg::OP_RANK,   20'h80000, K_W'($urandom()), rand_gap());
        send_word(btos_pkg::OP_RANK,   '1,        K_W'($urandom()), rand_gap());
        send_word(btos_pkg::OP_SELECT, KEY_W'($urandom()), '1, rand_gap());
        send_word(btos_pkg::OP_INSERT, '0, K_W'($urandom()), rand_gap());
        send_word(btos_pkg::OP_REMOVE, '0, K_W'($urandom()), rand_gap());
        send_word(btos_pkg::OP_INSERT, '0, K_W'($urandom()), rand_gap());
        send_word(btos_pkg::OP_SELECT, KEY_W'($urandom()), 16'd1, rand_gap());
        send_word(btos_pkg::OP_INSERT, '1, K_W'($urandom()), rand_gap());
    endtask

    initial
    begin
        for (int n = 0; n < 2 * NODE_POOL; n++)
            trie_link[n] = '0;
        for (int n = 0; n < NODE_POOL; n++)
            trie_count[n] = '0;
        alloc_next = 2;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The block clears its node memory after reset and holds busy meanwhile;
        // the first word simply waits for it.
        test_empty_trie();
        test_directed_ops();
        test_random_mix();
        test_pool_exhaustion();
        start <= 1'b0;

        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("binary_trie_order_statistics verification clean");
        else
            $display("binary_trie_order_statistics verification failed");
        $finish;
    end

endmodule
